// ===== rtl/rtc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the rgb to chromaticity converter
// no dependencies
package rtc_pkg;

	localparam int SET_W   = 16;   // gun setting width
	localparam int SCALE_W = 16;   // luminance scale width, Q8.8
	localparam int LUM_W   = 32;   // per-gun luminance magnitude, Q.8
	localparam int TOT_W   = 33;   // total luminance width
	localparam int COEF_W  = 20;   // matrix coefficient width, Q.20
	localparam int PROD_W  = COEF_W + LUM_W;
	localparam int NUM_W   = PROD_W + 3;       // signed weighted sum
	localparam int DEN_W   = TOT_W + 5;        // total * 32
	localparam int QUO_W   = 15;               // chroma magnitude never reaches 2^15
	localparam int CHR_W   = 16;

	localparam int LANES     = 3;
	localparam int LANE_LAT  = LUM_W;          // one quotient bit per stage
	localparam int MERGE_LAT = 3;
	localparam int DIV_LAT   = QUO_W + 1;
	localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT + DIV_LAT + 1;

	localparam logic [1:0] REG_SCALE_RED   = 2'd0;
	localparam logic [1:0] REG_SCALE_GREEN = 2'd1;
	localparam logic [1:0] REG_SCALE_BLUE  = 2'd2;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	localparam logic [COEF_W-1:0] COEF_R [LANES] = '{20'd865181, 20'd649292, 20'd561624};
	localparam logic [COEF_W-1:0] COEF_B [LANES] = '{20'd1430, 20'd2619, 20'd164737};

	typedef struct packed {
		logic [LUM_W-1:0] mag;
		logic             neg;
	} lum_t;

endpackage

// ===== rtl/rtc_lum_lane.sv =====
`timescale 1ns / 1ps
// one gun lane: |setting| * 65536 / scale, one quotient bit per pipeline stage
// depends on rtc_pkg
module rtc_lum_lane (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [rtc_pkg::SET_W-1:0] setting,
	input  logic [rtc_pkg::SCALE_W-1:0]      scale,
	output rtc_pkg::lum_t                    lum
);

	localparam int W = rtc_pkg::LUM_W;

	logic [rtc_pkg::SCALE_W-1:0] rem_s [1:W];
	logic [W-1:0]                dvd_s [1:W];
	logic [W-1:0]                quo_s [1:W];
	logic                        neg_s [1:W];

	logic [rtc_pkg::SET_W-1:0] mag0;
	logic [W-1:0]              dvd0;

	assign mag0 = setting[rtc_pkg::SET_W-1] ? (~setting + 1'b1) : setting;
	assign dvd0 = {mag0, {(W - rtc_pkg::SET_W){1'b0}}};

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [rtc_pkg::SCALE_W-1:0] rem_p;
		logic [W-1:0]                dvd_p;
		logic [W-1:0]                quo_p;
		logic                        neg_p;
		logic [rtc_pkg::SCALE_W:0]   trial;
		logic                        ge;

		if (i == 0) begin : g_first
			assign rem_p = '0;
			assign dvd_p = dvd0;
			assign quo_p = '0;
			assign neg_p = setting[rtc_pkg::SET_W-1];
		end else begin : g_next
			assign rem_p = rem_s[i];
			assign dvd_p = dvd_s[i];
			assign quo_p = quo_s[i];
			assign neg_p = neg_s[i];
		end

		assign trial = {rem_p, dvd_p[W-1]};
		assign ge    = trial >= {1'b0, scale};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rtc_pkg::SCALE_W'(trial - {1'b0, scale})
				                 : rtc_pkg::SCALE_W'(trial);
				dvd_s[i+1] <= {dvd_p[W-2:0], 1'b0};
				quo_s[i+1] <= {quo_p[W-2:0], ge};
				neg_s[i+1] <= neg_p;
			end
		end
	end

	assign lum.mag = quo_s[W];
	assign lum.neg = neg_s[W];

endmodule

// ===== rtl/rtc_chroma_div.sv =====
`timescale 1ns / 1ps
// rounding divider for one chroma row: (|num| + den/2) / den, one bit per stage
// depends on rtc_pkg
module rtc_chroma_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [rtc_pkg::NUM_W-1:0] num,
	input  logic [rtc_pkg::DEN_W-1:0]        den,
	output logic [rtc_pkg::QUO_W-1:0]        quo,
	output logic                             neg
);

	localparam int RW = rtc_pkg::NUM_W + 1;
	localparam int Q  = rtc_pkg::QUO_W;

	logic [RW-1:0]               rem_s [0:Q];
	logic [rtc_pkg::DEN_W-1:0]   den_s [0:Q];
	logic [Q-1:0]                quo_s [0:Q];
	logic                        neg_s [0:Q];

	logic [rtc_pkg::NUM_W-1:0] mag;
	assign mag = num[rtc_pkg::NUM_W-1] ? (~num + 1'b1) : num;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(mag) + RW'(den >> 1);
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= num[rtc_pkg::NUM_W-1];
		end
	end

	for (genvar i = 0; i < Q; i++) begin : g_stage
		logic [RW-1:0] dsh;
		logic          ge;
		assign dsh = RW'(den_s[i]) << (Q - 1 - i);
		assign ge  = rem_s[i] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - dsh : rem_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= {quo_s[i][Q-2:0], ge};
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign quo = quo_s[Q];
	assign neg = neg_s[Q];

endmodule

// ===== rtl/rgb_to_chromaticity.sv =====
`timescale 1ns / 1ps
// top level of the rgb to chromaticity converter
// depends on rtc_pkg, rtc_lum_lane, rtc_chroma_div
//
// usage
//   s_* carries one pixel request per accepted beat: three signed gun settings
//   m_* returns r and b chromaticity (signed Q1.15) and total luminance (Q.8)
//   cfg_* writes the per-gun luminance scales (Q8.8); always ready, write
//   only while no pixel is in flight; a zero scale acts as one LSB (1/256)
// pipeline and throughput
//   one pixel per cycle sustained while the output is not stalled; the
//   pipeline is the per-gun dividers (one quotient bit per stage, 32
//   stages), three merge stages (sum, multiply, weighted sum) and the
//   16-stage rounding divider for the chroma rows, plus the output register
// reset
//   arst_n clears the valid pipeline and loads all scales with 1.0
// stall
//   the whole pipeline holds while the output register is full and m_tready
//   is low; s_tready then drops in the same cycle
module rgb_to_chromaticity (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,    // red_setting, green_setting, blue_setting
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,    // r_chroma, b_chroma, total_luminance, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LAT = rtc_pkg::TOTAL_LAT;
	localparam int DL  = rtc_pkg::DIV_LAT;
	localparam int SW  = rtc_pkg::SET_W;

	// scale registers
	logic [rtc_pkg::SCALE_W-1:0] scale_q [rtc_pkg::LANES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rtc_pkg::LANES; i++) scale_q[i] <= rtc_pkg::SCALE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				rtc_pkg::REG_SCALE_RED:   scale_q[0] <= cfg_data;
				rtc_pkg::REG_SCALE_GREEN: scale_q[1] <= cfg_data;
				rtc_pkg::REG_SCALE_BLUE:  scale_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// global pipeline advance: move whenever the output slot is free or drains
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end

	// per-gun lanes
	rtc_pkg::lum_t lum [rtc_pkg::LANES];

	for (genvar g = 0; g < rtc_pkg::LANES; g++) begin : g_lane
		logic [rtc_pkg::SCALE_W-1:0] sc;
		assign sc = (scale_q[g] == '0) ? rtc_pkg::SCALE_W'(1) : scale_q[g];

		rtc_lum_lane u_lane (
			.clk     (clk),
			.en      (en),
			.setting (s_tdata[g*SW +: SW]),
			.scale   (sc),
			.lum     (lum[g])
		);
	end

	// merge stage 1: total luminance, lane results held for the multipliers
	logic [rtc_pkg::TOT_W-1:0] total_s1;
	rtc_pkg::lum_t             lum_s1 [rtc_pkg::LANES];

	always_ff @(posedge clk) begin
		if (en) begin
			total_s1 <= rtc_pkg::TOT_W'(lum[0].mag) + rtc_pkg::TOT_W'(lum[1].mag)
			          + rtc_pkg::TOT_W'(lum[2].mag);
			for (int i = 0; i < rtc_pkg::LANES; i++) lum_s1[i] <= lum[i];
		end
	end

	// merge stage 2: matrix products per lane, magnitudes only
	logic [rtc_pkg::PROD_W-1:0] prod_r_s2 [rtc_pkg::LANES];
	logic [rtc_pkg::PROD_W-1:0] prod_b_s2 [rtc_pkg::LANES];
	logic [rtc_pkg::LANES-1:0]  neg_s2;
	logic [rtc_pkg::TOT_W-1:0]  total_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < rtc_pkg::LANES; i++) begin
				prod_r_s2[i] <= rtc_pkg::PROD_W'(rtc_pkg::COEF_R[i]) * lum_s1[i].mag;
				prod_b_s2[i] <= rtc_pkg::PROD_W'(rtc_pkg::COEF_B[i]) * lum_s1[i].mag;
				neg_s2[i]    <= lum_s1[i].neg;
			end
			total_s2 <= total_s1;
		end
	end

	// merge stage 3: signed row sums
	logic signed [rtc_pkg::NUM_W-1:0] term_r [rtc_pkg::LANES];
	logic signed [rtc_pkg::NUM_W-1:0] term_b [rtc_pkg::LANES];
	logic signed [rtc_pkg::NUM_W-1:0] num_r_s3;
	logic signed [rtc_pkg::NUM_W-1:0] num_b_s3;
	logic [rtc_pkg::TOT_W-1:0]        total_s3;

	always_comb begin
		for (int i = 0; i < rtc_pkg::LANES; i++) begin
			term_r[i] = neg_s2[i] ? -$signed({3'b000, prod_r_s2[i]})
			                      :  $signed({3'b000, prod_r_s2[i]});
			term_b[i] = neg_s2[i] ? -$signed({3'b000, prod_b_s2[i]})
			                      :  $signed({3'b000, prod_b_s2[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_r_s3 <= term_r[0] + term_r[1] + term_r[2];
			num_b_s3 <= term_b[0] + term_b[1] + term_b[2];
			total_s3 <= total_s2;
		end
	end

	// chroma dividers, one per matrix row
	logic [rtc_pkg::DEN_W-1:0] den;
	logic [rtc_pkg::QUO_W-1:0] quo_r, quo_b;
	logic                      neg_r, neg_b;

	assign den = {total_s3, 5'b00000};

	rtc_chroma_div u_div_r (
		.clk (clk), .en (en), .num (num_r_s3), .den (den), .quo (quo_r), .neg (neg_r)
	);

	rtc_chroma_div u_div_b (
		.clk (clk), .en (en), .num (num_b_s3), .den (den), .quo (quo_b), .neg (neg_b)
	);

	// total luminance rides alongside the dividers
	logic [rtc_pkg::TOT_W-1:0] total_d_q [DL];

	always_ff @(posedge clk) begin
		if (en) begin
			total_d_q[0] <= total_s3;
			for (int i = 1; i < DL; i++) total_d_q[i] <= total_d_q[i-1];
		end
	end

	// output register; a zero total forces an all-zero result
	logic [rtc_pkg::CHR_W-1:0] r_chr, b_chr;
	logic [rtc_pkg::TOT_W-1:0] tot;
	logic                      zero;
	logic [71:0]               tdata_q;

	assign tot   = total_d_q[DL-1];
	assign zero  = (tot == '0);
	assign r_chr = neg_r ? -{1'b0, quo_r} : {1'b0, quo_r};
	assign b_chr = neg_b ? -{1'b0, quo_b} : {1'b0, quo_b};

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q <= zero ? '0 : {7'b0, tot, b_chr, r_chr};
		end
	end

	assign m_tdata = tdata_q;

endmodule

// ===== rtl/rtc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the rgb to chromaticity converter
// depends on rgb_to_chromaticity (bound below)
module rtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        cfg_ready
);

	// a held result request stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// an empty output slot never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with output empty");

	// zero luminance gives zero chroma; padding stays clear and config stays ready
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64:32] == 33'd0 |-> m_tdata[31:0] == 32'd0)
		else $error("nonzero chroma with zero luminance");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:65] == 7'd0 && cfg_ready)
		else $error("padding set or config not ready");

endmodule

bind rgb_to_chromaticity rtc_checker u_rtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);
